[rtl/core/afs_pkg.sv]
// Shared constants and types for the AOS frame synchronizer and channel filter.
`default_nettype none

package afs_pkg;

	localparam int FRAME_LEN     = 1024;
	localparam int PAYLOAD_LEN   = 948;
	localparam int PAYLOAD_START = 10;
	localparam int PAYLOAD_END   = PAYLOAD_START + PAYLOAD_LEN;

	localparam int POS_W = $clog2(FRAME_LEN);

	localparam logic [31:0] SYNC_RESET = 32'h1ACF_FC1D;
	localparam logic [5:0]  CHAN_RESET = 6'd17;

	// frame byte positions of the header fields
	localparam logic [POS_W-1:0] POS_MARK_END = POS_W'(4);
	localparam logic [POS_W-1:0] POS_VCID     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CNT_HI   = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CNT_MID  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CNT_LO   = POS_W'(8);
	localparam logic [POS_W-1:0] POS_SIGNAL   = POS_W'(9);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);

	localparam logic [9:0] IDX_LAST = 10'(PAYLOAD_LEN - 1);

	// configuration register indexes
	localparam logic CFG_SYNC_MARKER = 1'b0;
	localparam logic CFG_WANTED_CHAN = 1'b1;

	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic [31:0] sync_marker;
		logic [5:0]  wanted_channel;
	} cfg_t;

	typedef struct packed {
		logic        emit;
		logic [7:0]  payload_byte;
		logic [9:0]  byte_index;
		logic [23:0] frame_count;
		logic        replay_flag;
		logic        last_of_frame;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/afs_framer.sv]
// Sync marker hunt, frame position tracking and header capture.
`default_nettype none

module afs_framer
	import afs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire cfg_t       cfg,
	output result_t         res
);

	logic [31:0]      window_q;
	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic             hit_q;
	logic [23:0]      count_q;
	logic             replay_q;

	logic [31:0] window_next;
	logic        in_payload;
	logic [9:0]  idx;

	assign window_next = {window_q[23:0], data_byte};
	assign idx         = 10'(pos_q - POS_W'(PAYLOAD_START));
	assign in_payload  = (32'(pos_q) >= PAYLOAD_START) && (32'(pos_q) < PAYLOAD_END);

	always_comb begin
		res.emit          = in_frame_q && in_payload && hit_q;
		res.payload_byte  = data_byte;
		res.byte_index    = idx;
		res.frame_count   = count_q;
		res.replay_flag   = replay_q;
		res.last_of_frame = (idx == IDX_LAST) || (pos_q == POS_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			replay_q   <= 1'b0;
		end else if (step) begin
			if (!in_frame_q) begin
				window_q <= window_next;
				if (window_next == cfg.sync_marker) begin
					in_frame_q <= 1'b1;
					pos_q      <= POS_MARK_END;
					hit_q      <= 1'b0;
				end
			end else begin
				case (pos_q)
					POS_VCID:    hit_q <= (data_byte[5:0] == cfg.wanted_channel);
					POS_CNT_HI:  count_q[23:16] <= data_byte;
					POS_CNT_MID: count_q[15:8] <= data_byte;
					POS_CNT_LO:  count_q[7:0] <= data_byte;
					POS_SIGNAL:  replay_q <= data_byte[7];
					default:     ;
				endcase
				// window restarts empty after the frame
				if (pos_q == POS_LAST) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
					window_q   <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/aos_frame_sync_vc_extract.sv]
// Top level: AOS frame synchronizer with virtual channel payload extraction.
`default_nettype none

// Takes one received byte per cycle when not stalled and hunts for the
// configured 32-bit sync marker; a match starts a 1024-byte frame. The virtual
// channel id (byte 5), 24-bit frame counter (bytes 6..8) and replay flag (byte
// 9, top bit) are captured, and if the channel equals wanted_channel the 948
// payload bytes are sent out one per item, tagged with index, counter and flag,
// tlast on the final one. Hunting resumes after the frame ends. Each item passes
// an input register and a result register, with the single framer step between
// them; one item per cycle sustained while the output is not stalled.
// Write configuration only while the block is idle; it is not enforced.
module aos_frame_sync_vc_extract
	import afs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [7:0] payload_byte, [17:8] byte_index, [41:18] frame_count,
	// [42] replay_flag, [47:43] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast,   // last_of_frame
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [31:0]           cfg_data
);

	cfg_t    cfg_q;
	result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       step;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [9:0]  out_idx_q;
	logic [23:0] out_count_q;
	logic        out_replay_q;
	logic        out_last_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_marker    <= SYNC_RESET;
			cfg_q.wanted_channel <= CHAN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_MARKER: cfg_q.sync_marker <= cfg_data;
				CFG_WANTED_CHAN: cfg_q.wanted_channel <= cfg_data[5:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	afs_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			out_byte_q   <= res.payload_byte;
			out_idx_q    <= res.byte_index;
			out_count_q  <= res.frame_count;
			out_replay_q <= res.replay_flag;
			out_last_q   <= res.last_of_frame;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_replay_q, out_count_q, out_idx_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[tb/aos_frame_sync_vc_extract_tb.sv]
// Testbench for the AOS frame synchronizer and virtual channel payload filter.
module aos_frame_sync_vc_extract_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import afs_pkg::*;

	typedef struct {
		logic [7:0]  data;
		logic [9:0]  index;
		logic [23:0] count;
		logic        replay;
		logic        last;
	} payload_item_t;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_EVERY3} rx_mode_t;

	// Tracks the framer state byte by byte and holds the payload items still owed.
	class vc_payload_scoreboard;
		logic [31:0]      marker;
		logic [5:0]       chan_sel;
		logic [31:0]      hunt_shift;
		bit               locked;
		logic [POS_W-1:0] byte_pos;
		bit               vc_match;
		logic [23:0]      vcfc;
		logic             replay_bit;
		payload_item_t    payload_q[$];
		int unsigned      mismatches;

		function new();
			marker      = SYNC_RESET;
			chan_sel    = CHAN_RESET;
			hunt_shift  = '0;
			locked      = 1'b0;
			byte_pos    = '0;
			vc_match    = 1'b0;
			vcfc        = '0;
			replay_bit  = 1'b0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == CFG_SYNC_MARKER) begin
				marker = val;
			end else begin
				chan_sel = val[5:0];
			end
		endfunction

		function int pending();
			return payload_q.size();
		endfunction

		function void take_stream_byte(logic [7:0] b);
			payload_item_t item;
			int            idx;
			if (!locked) begin
				hunt_shift = {hunt_shift[23:0], b};
				if (hunt_shift == marker) begin
					locked   = 1'b1;
					byte_pos = POS_MARK_END;
					vc_match = 1'b0;
				end
				return;
			end
			case (byte_pos)
				POS_VCID: begin
					vc_match = (b[5:0] == chan_sel);
				end
				POS_CNT_HI: begin
					vcfc = {b, 16'h0000};
				end
				POS_CNT_MID: begin
					vcfc[15:8] = b;
				end
				POS_CNT_LO: begin
					vcfc[7:0] = b;
				end
				POS_SIGNAL: begin
					replay_bit = b[7];
				end
				default: begin
					idx = int'(byte_pos) - PAYLOAD_START;
					if (idx >= 0 && idx < PAYLOAD_LEN && vc_match) begin
						item.data   = b;
						item.index  = idx[9:0];
						item.count  = vcfc;
						item.replay = replay_bit;
						item.last   = (idx[9:0] == IDX_LAST) || (byte_pos == POS_LAST);
						payload_q.insert(payload_q.size(), item);
					end
				end
			endcase
			if (byte_pos == POS_LAST) begin
				locked     = 1'b0;
				byte_pos   = '0;
				hunt_shift = '0;
			end else begin
				byte_pos = byte_pos + 1'b1;
			end
		endfunction

		task report_mismatch(string what);
			if (mismatches < 50)
				$display("%0t ns: MISMATCH %s", $time, what);
			mismatches++;
		endtask

		task match_payload(logic [OUT_DATA_W-1:0] tdata, logic tlast);
			payload_item_t want;
			if (payload_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item tdata=%h tlast=%b", tdata, tlast));
				return;
			end
			want = payload_q.pop_front();
			if (tdata[7:0] !== want.data)
				report_mismatch($sformatf("payload_byte %h, want %h", tdata[7:0], want.data));
			if (tdata[17:8] !== want.index)
				report_mismatch($sformatf("byte_index %0d, want %0d", tdata[17:8], want.index));
			if (tdata[41:18] !== want.count)
				report_mismatch($sformatf("frame_count %h, want %h", tdata[41:18], want.count));
			if (tdata[42] !== want.replay)
				report_mismatch($sformatf("replay_flag %b, want %b", tdata[42], want.replay));
			if (tlast !== want.last)
				report_mismatch($sformatf("last_of_frame %b, want %b at index %0d",
					tlast, want.last, want.index));
			if (tdata[OUT_DATA_W-1:43] !== '0)
				report_mismatch($sformatf("padding bits %h not zero", tdata[OUT_DATA_W-1:43]));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [31:0]           cfg_data;

	vc_payload_scoreboard sb = new();

	bit gaps_on;
	bit hold_req;
	int burst_left;

	aos_frame_sync_vc_extract u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.match_payload(m_axis_tdata, m_axis_tlast);
	end

	// Receiver: segments of varying back-pressure, plus one long hold-off on request.
	initial begin
		rx_mode_t mode;
		int       seg;
		int       cyc;
		m_axis_tready = 1'b0;
		cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(10, 150);
			repeat (seg) begin
				@(negedge clk);
				cyc++;
				if (hold_req) begin
					hold_req = 1'b0;
					m_axis_tready <= 1'b0;
					repeat (600) @(negedge clk);
				end
				case (mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					RX_EVERY3: m_axis_tready <= (cyc % 3 == 0);
					default:   m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (gaps_on && burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_stream_byte(b);
	endtask

	// Stop sending and wait until every payload item owed has come out.
	task automatic settle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Random bytes, with broken marker prefixes mixed in.
	task automatic send_noise(input int n);
		int          k;
		int          pre;
		logic [31:0] m;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 5) == 0) begin
				m   = sb.marker;
				pre = $urandom_range(1, 3);
				for (int j = 0; j < pre; j++)
					send_byte(m[8*(3-j) +: 8]);
				k += pre;
			end else begin
				send_byte(8'($urandom));
				k++;
			end
		end
	endtask

	// Marker, header and the first n_pay payload bytes of one frame; the payload
	// carries a copy of the marker, which must not restart the frame.
	task automatic send_frame(input logic [7:0] vc_byte, input logic [23:0] cnt,
			input logic [7:0] sig, input bit mid_write, input int n_pay);
		logic [31:0] m;
		logic [7:0]  b;
		int          emb;
		m = sb.marker;
		for (int i = 3; i >= 0; i--)
			send_byte(m[8*i +: 8]);
		send_byte(8'($urandom));
		if (mid_write) begin
			// channel is sampled at the id byte, so a write just before it turns
			// this frame into a miss
			settle();
			write_reg(CFG_WANTED_CHAN, {26'($urandom), vc_byte[5:0] ^ 6'h01});
			write_reg(CFG_SYNC_MARKER, $urandom);
		end
		send_byte(vc_byte);
		send_byte(cnt[23:16]);
		send_byte(cnt[15:8]);
		send_byte(cnt[7:0]);
		send_byte(sig);
		emb = $urandom_range(PAYLOAD_START + 2, PAYLOAD_START + n_pay - 4);
		for (int i = PAYLOAD_START; i < PAYLOAD_START + n_pay; i++) begin
			if (i == PAYLOAD_START)
				b = 8'h00;
			else if (i == PAYLOAD_START + 1)
				b = 8'hFF;
			else if (i >= emb && i < emb + 4)
				b = sb.marker[8*(3-(i-emb)) +: 8];
			else
				b = 8'($urandom);
			send_byte(b);
		end
	endtask

	initial begin
		int sel;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SYNC_MARKER;
		cfg_data      = '0;
		gaps_on       = 1'b0;
		hold_req      = 1'b0;
		burst_left    = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: byte extremes, a broken marker, then a full matching frame with
		// counter all ones and the replay flag set
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h1A);
		send_byte(8'hCF);
		send_byte(8'hFC);
		send_byte(8'h55);
		gaps_on = ($urandom_range(0, 3) != 0);
		// receiver holds off while the payload streams in, so the block fills up
		hold_req = 1'b1;
		send_frame({2'b11, CHAN_RESET}, 24'hFF_FFFF, 8'h80, 1'b0,
			FRAME_LEN - PAYLOAD_START);
		send_noise(5);
		settle();

		sel = $urandom_range(0, 3);
		case (sel)
			0: begin
				write_reg(CFG_SYNC_MARKER, $urandom);
				write_reg(CFG_WANTED_CHAN, $urandom);
			end
			1: begin
				// zero marker matches on the first zero byte after hunting resumes
				write_reg(CFG_SYNC_MARKER, 32'h0000_0000);
				write_reg(CFG_WANTED_CHAN, 32'h0000_0000);
			end
			2: begin
				write_reg(CFG_SYNC_MARKER, 32'hFFFF_FFFF);
				write_reg(CFG_WANTED_CHAN, 32'hFFFF_FFFF);
			end
			default: begin
				write_reg(CFG_SYNC_MARKER, SYNC_RESET);
				write_reg(CFG_WANTED_CHAN, 32'h0000_002A);
			end
		endcase
		gaps_on = ($urandom_range(0, 3) != 0);
		send_noise($urandom_range(0, 30));
		// start of a second frame whose channel no longer matches
		send_frame({2'($urandom), sb.chan_sel}, 24'($urandom), 8'($urandom), 1'b1, 120);
		settle();

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
